[design/tac_pkg.sv]
package tac_pkg;

   localparam int unsigned SAMPLE_COUNT = 5;
   localparam int unsigned CHANNELS     = 2;
   localparam int unsigned ADC_BITS     = 10;

   localparam int unsigned FULL_SCALE = (1 << ADC_BITS) - 1;
   localparam int unsigned SUM_SPAN   = FULL_SCALE * SAMPLE_COUNT;
   localparam int unsigned SUM_W      = $clog2(SUM_SPAN + 1);
   localparam int unsigned CNT_W      = $clog2(SAMPLE_COUNT + 1);
   localparam int unsigned CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = 1;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOM_T   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 2'd3;

   localparam logic [29:0]        LN2_Q30      = 30'd744261118;
   localparam logic [16:0]        ZERO_C_CENTI = 17'd27315;
   localparam logic [16:0]        TC_MAX       = 17'd60082;
   localparam logic signed [15:0] TEMP_FLOOR   = -16'sd27315;
   localparam logic signed [15:0] TEMP_CEIL    = 16'sd32767;

   typedef struct packed {
      logic       probe_channel;
      logic [9:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic               result_channel;
      logic signed [15:0] temperature_centi;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [19:0]       series_resistance;
      logic [19:0]       nominal_resistance;
      logic signed [8:0] nominal_temperature;
      logic [13:0]       beta_coefficient;
   } cfg_type;

   typedef struct packed {
      logic             ch;
      logic [SUM_W-1:0] sum;
      logic             bad;
   } job_type;

endpackage

[design/tac_front.sv]
module tac_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tac_pkg::req_type  req_payload,
   input  logic              q_full,
   output logic              push,
   output tac_pkg::job_type  push_job
);

   logic [tac_pkg::SUM_W-1:0] sum_ff [tac_pkg::CHANNELS];
   logic [tac_pkg::CNT_W-1:0] cnt_ff [tac_pkg::CHANNELS];

   logic [tac_pkg::CH_IDX_W-1:0] ch;
   logic                         ch_ok;
   logic                         accept;
   logic [tac_pkg::SUM_W-1:0]    sample;
   logic [tac_pkg::SUM_W-1:0]    sum_new;
   logic [tac_pkg::CNT_W-1:0]    cnt_new;
   logic                         full_set;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign ch        = tac_pkg::CH_IDX_W'(req_payload.probe_channel);
   assign ch_ok     = 32'(req_payload.probe_channel) < tac_pkg::CHANNELS;
   assign sample    = tac_pkg::SUM_W'(req_payload.adc_sample & 10'(tac_pkg::FULL_SCALE));
   assign sum_new   = sum_ff[ch] + sample;
   assign cnt_new   = cnt_ff[ch] + tac_pkg::CNT_W'(1);
   assign full_set  = cnt_new == tac_pkg::CNT_W'(tac_pkg::SAMPLE_COUNT);

   assign push          = accept && ch_ok && full_set;
   assign push_job.ch   = req_payload.probe_channel;
   assign push_job.sum  = sum_new;
   assign push_job.bad  = (sum_new == '0) ||
                          (sum_new >= tac_pkg::SUM_W'(tac_pkg::SUM_SPAN));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tac_pkg::CHANNELS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (accept && ch_ok) begin
         if (full_set) begin
            sum_ff[ch] <= '0;
            cnt_ff[ch] <= '0;
         end else begin
            sum_ff[ch] <= sum_new;
            cnt_ff[ch] <= cnt_new;
         end
      end
   end

endmodule

[design/tac_queue.sv]
module tac_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tac_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             job_valid,
   output tac_pkg::job_type pop_job
);

   tac_pkg::job_type               entries_ff [tac_pkg::Q_DEPTH];
   logic [tac_pkg::Q_PTR_W-1:0]    wr_ptr_ff;
   logic [tac_pkg::Q_PTR_W-1:0]    rd_ptr_ff;
   logic [tac_pkg::Q_PTR_W:0]      fill_ff;
   logic                           do_pop;

   assign full      = fill_ff == (tac_pkg::Q_PTR_W + 1)'(tac_pkg::Q_DEPTH);
   assign job_valid = fill_ff != '0;
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && job_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + tac_pkg::Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + tac_pkg::Q_PTR_W'(1);
         end
         if (push && !do_pop) begin
            fill_ff <= fill_ff + (tac_pkg::Q_PTR_W + 1)'(1);
         end else if (do_pop && !push) begin
            fill_ff <= fill_ff - (tac_pkg::Q_PTR_W + 1)'(1);
         end
      end
   end

endmodule

[design/tac_back.sv]
module tac_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  tac_pkg::job_type job,
   output logic             job_pop,
   input  tac_pkg::cfg_type cfg,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tac_pkg::rsp_type rsp_payload
);

   localparam int unsigned V_W   = 20 + tac_pkg::SUM_W;
   localparam int unsigned E_W   = $clog2(V_W);
   localparam int unsigned LOG_W = E_W + 16;
   localparam int unsigned LNP_W = LOG_W + 30;
   localparam int unsigned LN_W  = LOG_W + 1;
   localparam int unsigned DEN_W = 41;
   localparam int unsigned NUM_W = 38;
   localparam int unsigned REM_W = 58;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_NORM = 4'd1;
   localparam logic [3:0] S_SQ   = 4'd2;
   localparam logic [3:0] S_LN   = 4'd3;
   localparam logic [3:0] S_DEN  = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_SAT  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0]                state_ff;
   logic                      ch_ff;
   logic                      bad_ff;
   logic [tac_pkg::SUM_W-1:0] sum_ff;
   logic                      sel_b_ff;
   logic [V_W-1:0]            v_ff;
   logic [E_W-1:0]            e_ff;
   logic [30:0]               m_ff;
   logic [15:0]               frac_ff;
   logic [4:0]                step_ff;
   logic [LOG_W-1:0]          la_ff;
   logic [LOG_W-1:0]          lb_ff;
   logic signed [LN_W-1:0]    ln_ff;
   logic signed [17:0]        t0c_ff;
   logic signed [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]          num_hi_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [REM_W-1:0]          dsh_ff;
   logic [16:0]               q_ff;
   logic signed [15:0]        temp_ff;
   logic                      rsp_valid_ff;
   tac_pkg::rsp_type          rsp_ff;

   logic [tac_pkg::SUM_W-1:0] span;
   logic [V_W-1:0]            a_prod;
   logic [V_W-1:0]            b_prod;
   logic [61:0]               sq;
   logic [31:0]               sq_t;
   logic [LOG_W-1:0]          log_val;
   logic [LOG_W-1:0]          mag;
   logic [LNP_W-1:0]          ln_prod;
   logic [LOG_W-1:0]          lnmag;
   logic [20:0]               beta100;
   logic signed [DEN_W-1:0]   ln_x;
   logic signed [DEN_W-1:0]   t0c_x;
   logic signed [DEN_W-1:0]   den_c;
   logic [NUM_W-1:0]          num_c;
   logic                      zero_reg;
   logic                      div_ge;
   logic [16:0]               q_next;
   logic signed [15:0]        temp_c;

   assign span     = tac_pkg::SUM_W'(tac_pkg::SUM_SPAN) - sum_ff;
   assign a_prod   = V_W'(cfg.series_resistance) * V_W'(job.sum);
   assign b_prod   = V_W'(cfg.nominal_resistance) * V_W'(span);
   assign sq       = 62'(m_ff) * 62'(m_ff);
   assign sq_t     = sq[61:30];
   assign log_val  = {e_ff, frac_ff[14:0], sq_t[31]};
   assign mag      = (la_ff >= lb_ff) ? (la_ff - lb_ff) : (lb_ff - la_ff);
   assign ln_prod  = LNP_W'(mag) * LNP_W'(tac_pkg::LN2_Q30) + (LNP_W'(1) << 29);
   assign lnmag    = ln_prod[LNP_W-1:30];
   assign beta100  = 21'(cfg.beta_coefficient) * 21'd100;
   assign ln_x     = {{(DEN_W-LN_W){ln_ff[LN_W-1]}}, ln_ff};
   assign t0c_x    = {{(DEN_W-18){t0c_ff[17]}}, t0c_ff};
   assign den_c    = ln_x * t0c_x + $signed({4'b0, beta100, 16'b0});
   assign num_c    = NUM_W'(beta100) * NUM_W'(t0c_ff[16:0]);
   assign zero_reg = (cfg.series_resistance == '0) || (cfg.nominal_resistance == '0) ||
                     (cfg.beta_coefficient == '0);
   assign div_ge   = rem_ff >= dsh_ff;
   assign q_next   = {q_ff[15:0], div_ge};
   // tc is never negative, so only the upper end needs clamping
   assign temp_c   = (q_next > tac_pkg::TC_MAX) ? tac_pkg::TEMP_CEIL :
                     $signed(16'(q_next - tac_pkg::ZERO_C_CENTI));

   assign job_pop     = (state_ff == S_IDLE) && job_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  ch_ff    <= job.ch;
                  bad_ff   <= job.bad;
                  sum_ff   <= job.sum;
                  v_ff     <= a_prod;
                  e_ff     <= E_W'(V_W - 1);
                  sel_b_ff <= 1'b0;
                  if (job.bad || zero_reg) begin
                     temp_ff  <= tac_pkg::TEMP_FLOOR;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_NORM;
                  end
               end
            end
            S_NORM: begin
               // coarse shift by a byte first, then single bits
               if (v_ff[V_W-1 -: 8] == '0 && e_ff >= E_W'(8)) begin
                  v_ff <= v_ff << 8;
                  e_ff <= e_ff - E_W'(8);
               end else if (!v_ff[V_W-1]) begin
                  v_ff <= v_ff << 1;
                  e_ff <= e_ff - E_W'(1);
               end else begin
                  m_ff     <= v_ff[V_W-1 -: 31];
                  frac_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               m_ff    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
               frac_ff <= {frac_ff[14:0], sq_t[31]};
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd15) begin
                  if (!sel_b_ff) begin
                     la_ff    <= log_val;
                     v_ff     <= b_prod;
                     e_ff     <= E_W'(V_W - 1);
                     sel_b_ff <= 1'b1;
                     state_ff <= S_NORM;
                  end else begin
                     lb_ff    <= log_val;
                     state_ff <= S_LN;
                  end
               end
            end
            S_LN: begin
               ln_ff    <= (la_ff >= lb_ff) ? $signed({1'b0, lnmag}) :
                                              -$signed({1'b0, lnmag});
               t0c_ff   <= {{9{cfg.nominal_temperature[8]}}, cfg.nominal_temperature} *
                           18'sd100 + 18'sd27315;
               state_ff <= S_DEN;
            end
            S_DEN: begin
               den_ff    <= den_c;
               num_hi_ff <= num_c;
               state_ff  <= S_CHK;
            end
            S_CHK: begin
               if (den_ff <= 0) begin
                  temp_ff  <= tac_pkg::TEMP_FLOOR;
                  state_ff <= S_DONE;
               end else begin
                  // numerator plus half the divisor, for round half up
                  rem_ff   <= REM_W'({num_hi_ff, 16'b0}) + REM_W'(den_ff[DEN_W-2:1]);
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               if (rem_ff >= REM_W'({den_ff[DEN_W-2:0], 17'b0})) begin
                  temp_ff  <= tac_pkg::TEMP_CEIL;
                  state_ff <= S_DONE;
               end else begin
                  dsh_ff   <= REM_W'({den_ff[DEN_W-2:0], 16'b0});
                  q_ff     <= '0;
                  step_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_ge) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               dsh_ff  <= dsh_ff >> 1;
               q_ff    <= q_next;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd16) begin
                  temp_ff  <= temp_c;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.result_channel    <= ch_ff;
                  rsp_ff.temperature_centi <= temp_ff;
                  rsp_ff.out_of_range      <= bad_ff;
                  state_ff                 <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[design/thermistor_average_to_celsius.sv]
// Thermistor probe averager with beta-equation conversion to centi-degrees C.
// req channel: one ADC sample per item, tagged with its probe. Samples are summed
// per probe; every fifth sample of a probe completes an average and queues one
// conversion job. Other items give no result.
// rsp channel: one item per completed average: probe, temperature in 0.01 C,
// and an out-of-range flag for an average of zero or full scale.
// An accepted sample joins its probe's sum. A conversion runs two log2 passes
// (normalize, then one squaring per fraction bit), the ln and denominator steps,
// a sign check, a saturation check and a 17-step divide; a non-positive
// denominator or a high saturation ends it early, and out-of-range items or a
// zero register skip it. The iterative converter takes one job at a time and so
// sets the throughput of averages; samples are taken while under two jobs wait.
// Reset clears the per-probe sums and counts, the queue and the output valid flag,
// and loads the default divider, thermistor and beta values.
// When the receiver stalls the result waits in the output register, the
// converter holds its next result, and the sample side stops once the queue fills.
// csr: write-only, csr_index selects series, nominal resistance, nominal temp, beta.
module thermistor_average_to_celsius (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tac_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tac_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_we,
   input  logic [tac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [19:0]                        csr_wdata
);

   tac_pkg::cfg_type cfg_ff;
   logic             q_full;
   logic             push;
   tac_pkg::job_type push_job;
   logic             job_valid;
   tac_pkg::job_type pop_job;
   logic             job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.series_resistance   <= 20'd10000;
         cfg_ff.nominal_resistance  <= 20'd10000;
         cfg_ff.nominal_temperature <= 9'sd25;
         cfg_ff.beta_coefficient    <= 14'd3950;
      end else if (csr_we) begin
         case (csr_index)
            tac_pkg::CSR_SERIES:  cfg_ff.series_resistance   <= csr_wdata;
            tac_pkg::CSR_NOMINAL: cfg_ff.nominal_resistance  <= csr_wdata;
            tac_pkg::CSR_NOM_T:   cfg_ff.nominal_temperature <= $signed(csr_wdata[8:0]);
            tac_pkg::CSR_BETA:    cfg_ff.beta_coefficient    <= csr_wdata[13:0];
            default: begin
            end
         endcase
      end
   end

   tac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   tac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (q_full),
      .job_valid (job_valid),
      .pop_job   (pop_job)
   );

   tac_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (pop_job),
      .job_pop     (job_pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[verif/thermistor_average_to_celsius_checker.sv]
module thermistor_average_to_celsius_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tac_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tac_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [tac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [19:0]      csr_wdata,
   output int               failures,
   output int               pending
);

   tac_pkg::cfg_type cfg;
   int unsigned      probe_sum [tac_pkg::CHANNELS];
   int unsigned      probe_cnt [tac_pkg::CHANNELS];
   tac_pkg::rsp_type temp_queue[$];

   assign pending = temp_queue.size();

   // Q16 log2, fraction truncated
   function automatic longint unsigned log2_q16(longint unsigned v);
      int unsigned     e;
      longint unsigned t, m, frac;
      e = 0;
      t = v;
      frac = 0;
      while (t > 1) begin
         t = t >> 1;
         e++;
      end
      m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(e) << 16) | frac;
   endfunction

   function automatic longint celsius_from_sum(longint unsigned sum);
      longint unsigned la, lb, mag, lnmag;
      longint          ln_q16, t0c, den, num, tc, temp;
      if (cfg.series_resistance == 0 || cfg.nominal_resistance == 0 ||
          cfg.beta_coefficient == 0)
         return -27315;
      la = log2_q16(longint'(cfg.series_resistance) * sum);
      lb = log2_q16(longint'(cfg.nominal_resistance) *
                    (longint'(tac_pkg::SUM_SPAN) - sum));
      mag = (la >= lb) ? la - lb : lb - la;
      lnmag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
      ln_q16 = (la >= lb) ? longint'(lnmag) : -longint'(lnmag);
      t0c = longint'(cfg.nominal_temperature) * 100 + 27315;
      den = ln_q16 * t0c + longint'(cfg.beta_coefficient) * 100 * 65536;
      if (den <= 0)
         return -27315;
      num = longint'(cfg.beta_coefficient) * 100 * t0c * 65536;
      tc = (num + den / 2) / den;
      temp = tc - 27315;
      if (temp > 32767) temp = 32767;
      if (temp < -27315) temp = -27315;
      return temp;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      failures++;
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      tac_pkg::rsp_type want, got;
      int unsigned      ch, sum;
      if (reset) begin
         cfg.series_resistance   <= 20'd10000;
         cfg.nominal_resistance  <= 20'd10000;
         cfg.nominal_temperature <= 9'sd25;
         cfg.beta_coefficient    <= 14'd3950;
         for (int c = 0; c < tac_pkg::CHANNELS; c++) begin
            probe_sum[c] = 0;
            probe_cnt[c] = 0;
         end
         temp_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               tac_pkg::CSR_SERIES:  cfg.series_resistance   <= csr_wdata;
               tac_pkg::CSR_NOMINAL: cfg.nominal_resistance  <= csr_wdata;
               tac_pkg::CSR_NOM_T:   cfg.nominal_temperature <= csr_wdata[8:0];
               tac_pkg::CSR_BETA:    cfg.beta_coefficient    <= csr_wdata[13:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            ch = req_payload.probe_channel;
            probe_sum[ch] += req_payload.adc_sample;
            probe_cnt[ch]++;
            if (probe_cnt[ch] >= tac_pkg::SAMPLE_COUNT) begin
               sum = probe_sum[ch];
               probe_sum[ch] = 0;
               probe_cnt[ch] = 0;
               want.result_channel = ch[0];
               want.out_of_range = (sum == 0) || (sum >= tac_pkg::SUM_SPAN);
               want.temperature_centi = want.out_of_range ? tac_pkg::TEMP_FLOOR
                                        : 16'(celsius_from_sum(sum));
               temp_queue.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (temp_queue.size() == 0) begin
               report("unexpected item", 1, 0);
            end else begin
               want = temp_queue.pop_front();
               if (got.result_channel !== want.result_channel)
                  report("result_channel", got.result_channel, want.result_channel);
               if (got.temperature_centi !== want.temperature_centi)
                  report("temperature_centi", got.temperature_centi,
                         want.temperature_centi);
               if (got.out_of_range !== want.out_of_range)
                  report("out_of_range", got.out_of_range, want.out_of_range);
            end
         end
      end
   end
endmodule

[verif/thermistor_average_to_celsius_test.sv]
module thermistor_average_to_celsius_test;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   tac_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   tac_pkg::rsp_type rsp_payload;
   logic             csr_we = 0;
   logic [tac_pkg::CSR_IDX_W-1:0] csr_index = tac_pkg::CSR_SERIES;
   logic [19:0]      csr_wdata = '0;
   int               failures, pending;
   int               send_idle = 35;
   int               recv_idle = 49;

   thermistor_average_to_celsius dut (.*);

   thermistor_average_to_celsius_checker checker_i (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock)
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle);

   initial begin
      #2000000;
      $display("** thermistor_average_to_celsius: FAILED **");
      $finish;
   end

   task automatic send_sample(bit ch, bit [9:0] s);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1;
      req_payload <= '{probe_channel: ch, adc_sample: s};
      do @(posedge clock); while (!req_ready);
   endtask

   // drain, then leave room for a conversion that produces nothing visible yet
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic cfg_write(logic [tac_pkg::CSR_IDX_W-1:0] idx, logic [19:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic set_cfg(logic [19:0] ser, logic [19:0] nom, logic [19:0] nt,
                          logic [19:0] beta);
      settle();
      cfg_write(tac_pkg::CSR_SERIES, ser);
      cfg_write(tac_pkg::CSR_NOMINAL, nom);
      cfg_write(tac_pkg::CSR_NOM_T, nt);
      cfg_write(tac_pkg::CSR_BETA, beta);
   endtask

   function automatic bit [9:0] pick_sample();
      case ($urandom_range(5))
         0: return 10'($urandom_range(3));
         1: return 10'(1023 - $urandom_range(3));
         2: return 10'($urandom_range(400, 620));
         default: return 10'($urandom_range(1023));
      endcase
   endfunction

   initial begin
      int sent;
      bit [9:0] d;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: zero average, full scale, mid, near ends, interleaved probes
      for (int i = 0; i < 5; i++) send_sample(1'b0, 10'd0);
      for (int i = 0; i < 5; i++) send_sample(1'b1, 10'd1023);
      for (int i = 0; i < 5; i++) begin
         send_sample(1'b0, 10'd512);
         send_sample(1'b1, (i == 0) ? 10'd1022 : 10'd1023);
      end
      for (int i = 0; i < 5; i++) send_sample(1'b0, (i == 0) ? 10'd1 : 10'd0);

      sent = 0;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: set_cfg(20'd1, 20'd1000000, 20'h100, 20'd16383);     // min temp, max beta
            1: set_cfg(20'd1000000, 20'd1, 20'h0FF, 20'd1000);
            2: set_cfg(20'd0, 20'd10000, 20'd25, 20'd3950);         // zero series
            3: set_cfg(20'd10000, 20'd0, 20'h1C9, 20'd0);           // zero nominal/beta
            4: set_cfg(20'hFFFFF, 20'hFFFFF, 20'h1FF, 20'hFFFFF);
            5: set_cfg(20'd10000, 20'd10000, 20'd150, 20'd10000);
            8: set_cfg(20'd10000, 20'd10000, 20'd25, 20'd3950);
            default: set_cfg(20'($urandom_range(1, 1000000)),
                             20'($urandom_range(1, 1000000)),
                             20'($urandom_range(511)), 20'($urandom_range(1000, 10000)));
         endcase
         while (sent < 180 * (phase + 1)) begin
            if (sent >= 1100) begin
               send_idle = 0;
               recv_idle = 0;
            end else if (sent >= 550) begin
               send_idle = 49;
               recv_idle = 35;
            end
            // bursts of one probe keep averages coherent; some mixing too
            d = pick_sample();
            if ($urandom_range(3) == 0) begin
               send_sample(1'($urandom_range(1)), d);
               sent++;
            end else begin
               for (int k = 0; k < 5; k++) send_sample(phase[0], d ^ 10'($urandom_range(3)));
               sent += 5;
            end
         end
      end
      settle();
      if (failures == 0 && pending == 0)
         $display("** thermistor_average_to_celsius: PASSED **");
      else
         $display("** thermistor_average_to_celsius: FAILED **");
      $finish;
   end
endmodule
